>>> rtl/gray_quantize_bit_packer_unit_assert.svh
// Assertion macros for the gray quantize bit packer unit.
`ifndef GRAY_QUANTIZE_BIT_PACKER_UNIT_ASSERT_SVH
`define GRAY_QUANTIZE_BIT_PACKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define GQBP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication, checked outside reset.
`define GQBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define GQBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GQBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GQBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define GQBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/gqbp_pkg.sv
// Shared types and constants for the gray quantize bit packer.
package gqbp_pkg;

	localparam int PIX_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int BPP_W      = 3;
	localparam int ACC_W      = 7;
	localparam int OUTQ_DEPTH = 4;

	localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

	// One queued output byte with its end-of-image flag.
	typedef struct packed {
		logic              final_byte;
		logic [BYTE_W-1:0] packed_byte;
	} out_entry_t;

	// Result of packing one pixel: bytes to push and the next packer state.
	typedef struct packed {
		logic [1:0]       count;
		out_entry_t       first;
		out_entry_t       second;
		logic [ACC_W-1:0] acc_nxt;
		logic [BPP_W-1:0] held_nxt;
	} pack_res_t;

endpackage

>>> rtl/gqbp_pack.sv
// Quantize one pixel and merge its code into the MSB-first byte accumulator.
module gqbp_pack (
	input  logic [gqbp_pkg::PIX_W-1:0] pixel,
	input  logic                       last_pixel,
	input  logic [gqbp_pkg::BPP_W-1:0] bits_per_pixel,
	input  logic [gqbp_pkg::ACC_W-1:0] acc,
	input  logic [gqbp_pkg::BPP_W-1:0] held,
	output gqbp_pkg::pack_res_t        res
);
	import gqbp_pkg::*;

	logic [BPP_W-1:0]  b;
	logic [2:0]        code_sh;
	logic [PIX_W-1:0]  code;
	logic [14:0]       combined;
	logic [3:0]        total;
	logic              full;
	logic [2:0]        rem;
	logic [14:0]       shifted;
	logic [7:0]        rem_mask;
	logic [ACC_W-1:0]  acc_next;
	logic [BPP_W-1:0]  held_next;
	logic [2:0]        pad_sh;
	logic [BYTE_W-1:0] pad_byte;
	logic              has_pad;

	always_comb begin
		b        = (bits_per_pixel == '0) ? 3'd1 : bits_per_pixel;
		code_sh  = 3'(4'd8 - {1'b0, b});
		code     = pixel >> code_sh;
		combined = ({8'b0, acc} << b) | {7'b0, code};
		total    = {1'b0, held} + {1'b0, b};
		full     = total[3];
		rem      = total[2:0];
		shifted  = combined >> rem;
		rem_mask = (8'd1 << rem) - 8'd1;

		if (full) begin
			acc_next  = combined[ACC_W-1:0] & rem_mask[ACC_W-1:0];
			held_next = rem;
		end else begin
			acc_next  = combined[ACC_W-1:0];
			held_next = total[2:0];
		end

		// Left-align the pending bits for the zero-padded flush byte.
		pad_sh   = 3'(4'd8 - {1'b0, held_next});
		pad_byte = 8'({1'b0, acc_next} << pad_sh);
		has_pad  = last_pixel && (held_next != '0);

		res.count                  = {1'b0, full} + {1'b0, has_pad};
		res.second.packed_byte     = pad_byte;
		res.second.final_byte      = 1'b1;
		if (full) begin
			res.first.packed_byte  = shifted[BYTE_W-1:0];
			res.first.final_byte   = last_pixel && (held_next == '0);
		end else begin
			res.first.packed_byte  = pad_byte;
			res.first.final_byte   = 1'b1;
		end

		// Start empty for the next image.
		if (last_pixel) begin
			res.acc_nxt  = '0;
			res.held_nxt = '0;
		end else begin
			res.acc_nxt  = acc_next;
			res.held_nxt = held_next;
		end
	end

endmodule

>>> rtl/gqbp_outq.sv
// Output queue: takes up to two bytes per cycle, sends one per transaction.
module gqbp_outq #(
	parameter int DEPTH = gqbp_pkg::OUTQ_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  push_cnt,
	input  gqbp_pkg::out_entry_t        push_first,
	input  gqbp_pkg::out_entry_t        push_second,
	output logic [$clog2(DEPTH+1)-1:0]  level,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [gqbp_pkg::BYTE_W-1:0] m_axis_tdata,
	output logic                        m_axis_tlast
);
	import gqbp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH+1);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH-1);

	out_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic [PTR_W-1:0] wr_ptr_p1;
	logic [PTR_W-1:0] wr_ptr_p2;
	logic [PTR_W-1:0] rd_ptr_p1;
	logic             pop;

	assign wr_ptr_p1 = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
	assign wr_ptr_p2 = (wr_ptr_p1 == LAST_IDX) ? '0 : wr_ptr_p1 + 1'b1;
	assign rd_ptr_p1 = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;

	assign m_axis_tvalid = (level_q != '0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = mem_q[rd_ptr_q].packed_byte;
	assign m_axis_tlast  = mem_q[rd_ptr_q].final_byte;
	assign level         = level_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push_first;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			case (push_cnt)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= wr_ptr_p2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= rd_ptr_p1;
			end
			level_q <= level_q + LVL_W'(push_cnt) - LVL_W'(pop);
		end
	end

endmodule

>>> rtl/gray_quantize_bit_packer_unit.sv
// Top level: quantize gray pixels and pack the codes MSB-first into bytes.
//
//  channel   | dir | tdata             | tlast       | notes
//  s_axis    | in  | [7:0] pixel       | last_pixel  | one pixel per transaction
//  m_axis    | out | [7:0] packed_byte | final_byte  | one byte per transaction
//  cfg       | in  | [2:0] bits_per_pixel            | write on cfg_wr_en
//
// A pixel is held in the input register; its bytes reach m_axis through an
// output queue of OUTQ_DEPTH entries. One pixel per cycle is sustained
// while the queue has room for two bytes; the queue drains one byte per
// cycle while m_axis_tready is high. Reset clears the packer to empty and
// the width to 4. A stall on m_axis holds pixels in the input register
// once more than OUTQ_DEPTH-2 bytes wait in the queue.
module gray_quantize_bit_packer_unit #(
	parameter int OUTQ_DEPTH = gqbp_pkg::OUTQ_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gqbp_pkg::BPP_W-1:0]  cfg_wr_data,   // [2:0] bits_per_pixel
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [gqbp_pkg::PIX_W-1:0]  s_axis_tdata,  // [7:0] pixel
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [gqbp_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] packed_byte
	output logic                        m_axis_tlast
);
	import gqbp_pkg::*;

	localparam int LVL_W = $clog2(OUTQ_DEPTH+1);
	localparam logic [LVL_W-1:0] ROOM_LVL = LVL_W'(OUTQ_DEPTH-2);

	logic [BPP_W-1:0] bpp_q;
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic             last_s1;
	logic [ACC_W-1:0] acc_q;
	logic [BPP_W-1:0] held_q;
	logic [LVL_W-1:0] level;
	logic             adv_s1;
	logic [1:0]       push_cnt;
	pack_res_t        res;

	// Advance only when the queue can take both bytes of a flush.
	assign adv_s1        = valid_s1 && (level <= ROOM_LVL);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign push_cnt      = adv_s1 ? res.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_RESET;
		end else if (cfg_wr_en) begin
			bpp_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
			held_q   <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				acc_q  <= res.acc_nxt;
				held_q <= res.held_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pixel_s1 <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
		end
	end

	gqbp_pack u_pack (
		.pixel          (pixel_s1),
		.last_pixel     (last_s1),
		.bits_per_pixel (bpp_q),
		.acc            (acc_q),
		.held           (held_q),
		.res            (res)
	);

	gqbp_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_cnt      (push_cnt),
		.push_first    (res.first),
		.push_second   (res.second),
		.level         (level),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

`include "gray_quantize_bit_packer_unit_assert.svh"

	`GQBP_ASSERT(a_level_bound, clk, arst_n, level <= LVL_W'(OUTQ_DEPTH), "queue overflow")
	`GQBP_ASSERT_NEXT(a_last_clears, clk, arst_n, adv_s1 && last_s1, held_q == '0 && acc_q == '0, "packer not empty after last pixel")
	`GQBP_ASSERT_IMPL(a_acc_fits, clk, arst_n, 1'b1, (acc_q >> held_q) == '0, "accumulator holds bits beyond count")

endmodule
